/* design/lob_pkg.sv */
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types, codes and default sizes of the limit order book matcher.
// ----------------------------------------------------------------------------
package lob_pkg;

	// default sizes
	localparam int DEF_PRICE_LEVELS = 1024;
	localparam int DEF_ORDER_SLOTS  = 1024;
	localparam int DEF_MAX_EVENTS   = 64;

	// request codes
	localparam logic CMD_NEW     = 1'b0;
	localparam logic CMD_CANCEL  = 1'b1;
	localparam logic SIDE_BUY    = 1'b0;
	localparam logic TYPE_MARKET = 1'b1;

	// event kinds
	localparam logic [2:0] EV_REST_FILL   = 3'd0;
	localparam logic [2:0] EV_AGGR_FILL   = 3'd1;
	localparam logic [2:0] EV_AGGR_NOFILL = 3'd2;
	localparam logic [2:0] EV_CANCEL_OK   = 3'd3;
	localparam logic [2:0] EV_CANCEL_REJ  = 3'd4;

	// order states
	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_PARTIAL  = 2'd1;
	localparam logic [1:0] ST_FILLED   = 2'd2;
	localparam logic [1:0] ST_UNFILLED = 2'd3;

	typedef struct packed {
		logic        command;
		logic [9:0]  order_id;
		logic        side;
		logic        order_type;
		logic [9:0]  limit_tick;
		logic [31:0] quantity;
	} req_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [9:0]  event_order;
		logic [9:0]  fill_tick;
		logic [31:0] fill_qty;
		logic [31:0] qty_left;
		logic [1:0]  order_state;
		logic        state_changed;
		logic [9:0]  best_bid;
		logic        bid_present;
		logic [9:0]  best_ask;
		logic        ask_present;
		logic        last;
	} evt_t;

	// one buffered event, before the book top is known
	typedef struct packed {
		logic [2:0]  kind;
		logic [9:0]  order;
		logic [9:0]  tick;
		logic [31:0] fill;
		logic [31:0] left;
		logic [1:0]  state;
		logic        changed;
	} ev_rec_t;

	typedef struct packed {
		logic [9:0] bid;
		logic       bid_ok;
		logic [9:0] ask;
		logic       ask_ok;
	} top_t;

	typedef struct packed {
		logic [31:0] traded;
		logic [31:0] rest_left;
		logic [31:0] aggr_left;
		logic [31:0] acc_sum;
		logic        rest_done;
	} trade_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_CHK,
		S_SW_LVL,
		S_SW_LAT,
		S_SW_HEAD,
		S_SW_TRADE,
		S_SW_LVEND,
		S_SW_END,
		S_RS_LVL,
		S_RS_APP,
		S_UN_LVL,
		S_UN_DO,
		S_SR_RD,
		S_SR_CHK,
		S_OUT_GO,
		S_OUT_WAIT
	} seq_state_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_RD,
		E_LD,
		E_HOLD
	} ev_state_t;

endpackage

/* design/lob_alu.sv */
// ----------------------------------------------------------------------------
// lob_alu
// Shared trade unit: matches a resting quantity against the incoming one.
// ----------------------------------------------------------------------------
module lob_alu (
	input  logic [31:0]     rest_qty,
	input  logic [31:0]     aggr_qty,
	input  logic [31:0]     acc_qty,
	output lob_pkg::trade_t res
);

	logic rest_le;

	// compare once, subtract both ways in parallel
	always_comb begin
		rest_le       = rest_qty <= aggr_qty;
		res.traded    = rest_le ? rest_qty : aggr_qty;
		res.rest_left = rest_le ? 32'd0 : rest_qty - aggr_qty;
		res.aggr_left = rest_le ? aggr_qty - rest_qty : 32'd0;
		res.acc_sum   = acc_qty + res.traded;
		res.rest_done = rest_le;
	end

endmodule

/* design/lob_evbuf.sv */
// ----------------------------------------------------------------------------
// lob_evbuf
// Event buffer: collects the events of one item, then replays them with the
// final book top attached, one transfer at a time.
// ----------------------------------------------------------------------------
module lob_evbuf #(
	parameter int MAX_EVENTS = lob_pkg::DEF_MAX_EVENTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ev_we,
	input  logic [$clog2(MAX_EVENTS)-1:0] ev_addr,
	input  lob_pkg::ev_rec_t              ev_rec,
	input  logic                          start,
	input  logic [$clog2(MAX_EVENTS)-1:0] count,
	input  lob_pkg::top_t                 top,
	output logic                          busy,
	output logic                          evt_valid,
	input  logic                          evt_stall,
	output lob_pkg::evt_t                 evt
);

	localparam int EW = $clog2(MAX_EVENTS);

	lob_pkg::ev_rec_t  mem [MAX_EVENTS];
	lob_pkg::ev_rec_t  rd_q;
	lob_pkg::ev_state_t state_q, state_d;
	logic [EW-1:0]     k_q;
	logic [EW-1:0]     count_q;
	logic              at_last;
	logic              valid_q;
	lob_pkg::evt_t     evt_q;

	// event store, registered read
	always_ff @(posedge clk) begin
		if (ev_we) begin
			mem[ev_addr] <= ev_rec;
		end
		rd_q <= mem[k_q];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lob_pkg::E_IDLE: if (start) state_d = lob_pkg::E_RD;
			lob_pkg::E_RD:   state_d = lob_pkg::E_LD;
			lob_pkg::E_LD:   state_d = lob_pkg::E_HOLD;
			lob_pkg::E_HOLD: begin
				if (!evt_stall) begin
					state_d = at_last ? lob_pkg::E_IDLE : lob_pkg::E_RD;
				end
			end
			default: state_d = lob_pkg::E_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy    = state_q != lob_pkg::E_IDLE;
		at_last = k_q == count_q - EW'(1);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lob_pkg::E_IDLE;
			k_q     <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				lob_pkg::E_IDLE: begin
					if (start) begin
						k_q     <= '0;
						count_q <= count;
					end
				end
				lob_pkg::E_LD: valid_q <= 1'b1;
				lob_pkg::E_HOLD: begin
					if (!evt_stall) begin
						valid_q <= 1'b0;
						k_q     <= k_q + EW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (state_q == lob_pkg::E_LD) begin
			evt_q.event_kind    <= rd_q.kind;
			evt_q.event_order   <= rd_q.order;
			evt_q.fill_tick     <= rd_q.tick;
			evt_q.fill_qty      <= rd_q.fill;
			evt_q.qty_left      <= rd_q.left;
			evt_q.order_state   <= rd_q.state;
			evt_q.state_changed <= rd_q.changed;
			evt_q.best_bid      <= top.bid;
			evt_q.bid_present   <= top.bid_ok;
			evt_q.best_ask      <= top.ask;
			evt_q.ask_present   <= top.ask_ok;
			evt_q.last          <= at_last;
		end
	end

	assign evt_valid = valid_q;
	assign evt       = evt_q;

endmodule

/* design/limit_order_book_matcher.sv */
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book: FIFO of resting orders per tick level and
// side, sweep matching of new orders, cancel by id, best bid / best ask.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload       | direction
//  request | req_valid | req_stall | req (req_t)   | in
//  event   | evt_valid | evt_stall | evt (evt_t)   | out
//
// One item at a time. An item passes through a lookup, a sweep of price
// levels with a trade per resting order matched, a search for a new best
// price level by level when one is needed, and a replay of its events, which
// evt_stall can hold. The level memory has a single read port. After reset a
// clearing pass runs with req_stall high.
// Events of an item leave only after all its work, carrying the final top.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
	parameter int PRICE_LEVELS = lob_pkg::DEF_PRICE_LEVELS,
	parameter int ORDER_SLOTS  = lob_pkg::DEF_ORDER_SLOTS,
	parameter int MAX_EVENTS   = lob_pkg::DEF_MAX_EVENTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lob_pkg::req_t req,
	output logic          evt_valid,
	input  logic          evt_stall,
	output lob_pkg::evt_t evt
);

	localparam int LW = $clog2(PRICE_LEVELS);
	localparam int LA = LW + 1;
	localparam int SW = $clog2(ORDER_SLOTS);
	localparam int EW = $clog2(MAX_EVENTS);
	localparam int CW = (LA > SW) ? LA : SW;
	localparam int RW = 2 * SW + 1;

	// sequencer state
	lob_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0] clr_q;
	logic [EW-1:0] n_q;
	logic          stop_q;
	logic          swept_q;
	logic [LW-1:0] bid_q, ask_q;
	logic          bid_ok_q, ask_ok_q;

	// item registers
	lob_pkg::req_t req_q;
	logic [SW-1:0] slot_q;
	logic [LW-1:0] lim_q;
	logic [31:0]   rem_q;
	logic [31:0]   acc_q;
	logic [LW-1:0] t_q;
	logic [LA-1:0] lv_q;
	logic [RW-1:0] lvl_q;
	logic [SW-1:0] unx_q, upv_q;
	logic          sr_side_q;
	logic [LW-1:0] sr_t_q;

	// memories and ports
	logic [RW-1:0] lvl_mem [2**LA];
	logic [RW-1:0] lvl_rd, lvl_wd;
	logic [LA-1:0] lvl_ra, lvl_wa;
	logic          lvl_we;

	logic          used_mem [2**SW];
	logic [SW-1:0] next_mem [2**SW];
	logic [SW-1:0] prev_mem [2**SW];
	logic [31:0]   remn_mem [2**SW];
	logic [LA-1:0] lvs_mem  [2**SW];
	logic          part_mem [2**SW];

	logic [SW-1:0] slot_ra;
	logic          used_rd, part_rd;
	logic [SW-1:0] next_rd, prev_rd;
	logic [31:0]   remn_rd;
	logic [LA-1:0] lvs_rd;

	logic          used_we, used_wd;
	logic [SW-1:0] used_wa;
	logic          next_we, prev_we;
	logic [SW-1:0] next_wa, next_wd, prev_wa, prev_wd;
	logic          remn_we;
	logic [SW-1:0] remn_wa;
	logic [31:0]   remn_wd;
	logic          lvs_we;
	logic [SW-1:0] lvs_wa;
	logic [LA-1:0] lvs_wd;
	logic          part_we, part_wd;
	logic [SW-1:0] part_wa;

	// event write
	logic             ev_we;
	lob_pkg::ev_rec_t ev_rec;
	logic             ev_start;
	logic             ev_busy;
	lob_pkg::top_t    top;

	// decoded conditions
	logic            is_buy, is_mkt, is_cancel, opp_ok, id_ok;
	logic [LW-1:0]   lim_in;
	logic            lim_hit, budget_out, t_end, sr_end;
	logic            q_busy, rd_busy;
	logic [SW-1:0]   q_head, q_tail, rd_head, rd_tail;
	logic            un_empty, un_best;
	logic [LA-1:0]   sw_lv;
	lob_pkg::trade_t trade;

	lob_alu u_alu (
		.rest_qty (remn_rd),
		.aggr_qty (rem_q),
		.acc_qty  (acc_q),
		.res      (trade)
	);

	// level store
	always_ff @(posedge clk) begin
		if (lvl_we) begin
			lvl_mem[lvl_wa] <= lvl_wd;
		end
		lvl_rd <= lvl_mem[lvl_ra];
	end

	// order pool stores, shared read address
	always_ff @(posedge clk) begin
		if (used_we) used_mem[used_wa] <= used_wd;
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (remn_we) remn_mem[remn_wa] <= remn_wd;
		if (lvs_we)  lvs_mem[lvs_wa]   <= lvs_wd;
		if (part_we) part_mem[part_wa] <= part_wd;
		used_rd <= used_mem[slot_ra];
		next_rd <= next_mem[slot_ra];
		prev_rd <= prev_mem[slot_ra];
		remn_rd <= remn_mem[slot_ra];
		lvs_rd  <= lvs_mem[slot_ra];
		part_rd <= part_mem[slot_ra];
	end

	// decode
	always_comb begin
		is_buy     = req_q.side == lob_pkg::SIDE_BUY;
		is_mkt     = req_q.order_type == lob_pkg::TYPE_MARKET;
		is_cancel  = req_q.command == lob_pkg::CMD_CANCEL;
		opp_ok     = is_buy ? ask_ok_q : bid_ok_q;
		id_ok      = 32'(req_q.order_id) < 32'(ORDER_SLOTS);
		lim_in     = (32'(req.limit_tick) >= 32'(PRICE_LEVELS)) ? LW'(PRICE_LEVELS - 1)
			: LW'(req.limit_tick);
		lim_hit    = !is_mkt && (is_buy ? (t_q > lim_q) : (t_q < lim_q));
		budget_out = (32'(n_q) + 32'd3) > 32'(MAX_EVENTS);
		t_end      = is_buy ? ((32'(t_q) + 32'd1) >= 32'(PRICE_LEVELS)) : (t_q == '0);
		sr_end     = sr_side_q ? ((32'(sr_t_q) + 32'd1) >= 32'(PRICE_LEVELS))
			: (sr_t_q == '0);
		q_busy     = lvl_q[2*SW];
		q_head     = lvl_q[2*SW-1:SW];
		q_tail     = lvl_q[SW-1:0];
		rd_busy    = lvl_rd[2*SW];
		rd_head    = lvl_rd[2*SW-1:SW];
		rd_tail    = lvl_rd[SW-1:0];
		un_empty   = rd_head == slot_q && rd_tail == slot_q;
		un_best    = lv_q[LW] ? (ask_ok_q && ask_q == lv_q[LW-1:0])
			: (bid_ok_q && bid_q == lv_q[LW-1:0]);
		sw_lv      = {~req_q.side, t_q};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lob_pkg::S_CLR:  if (clr_q == '1) state_d = lob_pkg::S_IDLE;
			lob_pkg::S_IDLE: if (req_valid) state_d = lob_pkg::S_CHK;
			lob_pkg::S_CHK: begin
				if (is_cancel) begin
					state_d = (!id_ok || !used_rd) ? lob_pkg::S_OUT_GO : lob_pkg::S_UN_LVL;
				end else if (!id_ok || used_rd || req_q.quantity == 32'd0) begin
					state_d = lob_pkg::S_IDLE;
				end else if (is_mkt && !opp_ok) begin
					state_d = lob_pkg::S_IDLE;
				end else begin
					state_d = opp_ok ? lob_pkg::S_SW_LVL : lob_pkg::S_RS_LVL;
				end
			end
			lob_pkg::S_SW_LVL: state_d = lim_hit ? lob_pkg::S_SW_END : lob_pkg::S_SW_LAT;
			lob_pkg::S_SW_LAT: state_d = lob_pkg::S_SW_HEAD;
			lob_pkg::S_SW_HEAD: begin
				state_d = (!q_busy || rem_q == 32'd0 || budget_out) ? lob_pkg::S_SW_LVEND
					: lob_pkg::S_SW_TRADE;
			end
			lob_pkg::S_SW_TRADE: state_d = lob_pkg::S_SW_HEAD;
			lob_pkg::S_SW_LVEND: begin
				state_d = (rem_q == 32'd0 || stop_q || t_end) ? lob_pkg::S_SW_END
					: lob_pkg::S_SW_LVL;
			end
			lob_pkg::S_SW_END: begin
				state_d = (is_mkt || rem_q == 32'd0) ? lob_pkg::S_SR_RD : lob_pkg::S_RS_LVL;
			end
			lob_pkg::S_RS_LVL: state_d = lob_pkg::S_RS_APP;
			lob_pkg::S_RS_APP: state_d = swept_q ? lob_pkg::S_SR_RD : lob_pkg::S_OUT_GO;
			lob_pkg::S_UN_LVL: state_d = lob_pkg::S_UN_DO;
			lob_pkg::S_UN_DO: begin
				state_d = (un_empty && un_best) ? lob_pkg::S_SR_RD : lob_pkg::S_OUT_GO;
			end
			lob_pkg::S_SR_RD:  state_d = lob_pkg::S_SR_CHK;
			lob_pkg::S_SR_CHK: state_d = (rd_busy || sr_end) ? lob_pkg::S_OUT_GO : lob_pkg::S_SR_RD;
			lob_pkg::S_OUT_GO: state_d = (n_q == '0) ? lob_pkg::S_IDLE : lob_pkg::S_OUT_WAIT;
			lob_pkg::S_OUT_WAIT: if (!ev_busy) state_d = lob_pkg::S_IDLE;
			default: state_d = lob_pkg::S_IDLE;
		endcase
	end

	// memory ports and event writes
	always_comb begin
		lvl_ra  = '0;
		lvl_we  = 1'b0; lvl_wa  = '0; lvl_wd  = '0;
		slot_ra = slot_q;
		used_we = 1'b0; used_wa = '0; used_wd = 1'b0;
		next_we = 1'b0; next_wa = '0; next_wd = '0;
		prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
		remn_we = 1'b0; remn_wa = '0; remn_wd = '0;
		lvs_we  = 1'b0; lvs_wa  = '0; lvs_wd  = '0;
		part_we = 1'b0; part_wa = '0; part_wd = 1'b0;
		ev_we   = 1'b0;
		ev_rec  = '0;
		case (state_q)
			lob_pkg::S_CLR: begin
				lvl_we  = 1'b1;
				lvl_wa  = clr_q[LA-1:0];
				used_we = 1'b1;
				used_wa = clr_q[SW-1:0];
			end
			lob_pkg::S_IDLE: slot_ra = SW'(req.order_id);
			lob_pkg::S_CHK: begin
				if (is_cancel) begin
					ev_we        = 1'b1;
					ev_rec.order = req_q.order_id;
					if (!id_ok || !used_rd) begin
						ev_rec.kind = lob_pkg::EV_CANCEL_REJ;
					end else begin
						ev_rec.kind  = lob_pkg::EV_CANCEL_OK;
						ev_rec.left  = remn_rd;
						ev_rec.state = part_rd ? lob_pkg::ST_PARTIAL : lob_pkg::ST_ACCEPTED;
					end
				end
			end
			lob_pkg::S_SW_LVL:  lvl_ra  = sw_lv;
			lob_pkg::S_SW_HEAD: slot_ra = q_head;
			lob_pkg::S_SW_TRADE: begin
				remn_we = 1'b1; remn_wa = q_head; remn_wd = trade.rest_left;
				part_we = 1'b1; part_wa = q_head; part_wd = 1'b1;
				if (trade.rest_done) begin
					used_we = 1'b1; used_wa = q_head;
					lvl_we  = 1'b1; lvl_wa  = sw_lv;
					lvl_wd  = (q_tail == q_head) ? '0 : {1'b1, next_rd, q_tail};
				end
				ev_we          = 1'b1;
				ev_rec.kind    = lob_pkg::EV_REST_FILL;
				ev_rec.order   = 10'(q_head);
				ev_rec.tick    = 10'(t_q);
				ev_rec.fill    = trade.traded;
				ev_rec.left    = trade.rest_left;
				ev_rec.state   = trade.rest_done ? lob_pkg::ST_FILLED : lob_pkg::ST_PARTIAL;
				ev_rec.changed = trade.rest_done || !part_rd;
			end
			lob_pkg::S_SW_LVEND: begin
				if (acc_q != 32'd0) begin
					ev_we          = 1'b1;
					ev_rec.kind    = lob_pkg::EV_AGGR_FILL;
					ev_rec.order   = req_q.order_id;
					ev_rec.tick    = 10'(t_q);
					ev_rec.fill    = acc_q;
					ev_rec.left    = rem_q;
					ev_rec.state   = (rem_q == 32'd0) ? lob_pkg::ST_FILLED : lob_pkg::ST_PARTIAL;
					ev_rec.changed = 1'b1;
				end
			end
			lob_pkg::S_SW_END: begin
				if (is_mkt && rem_q == req_q.quantity) begin
					ev_we          = 1'b1;
					ev_rec.kind    = lob_pkg::EV_AGGR_NOFILL;
					ev_rec.order   = req_q.order_id;
					ev_rec.left    = req_q.quantity;
					ev_rec.state   = lob_pkg::ST_UNFILLED;
					ev_rec.changed = 1'b1;
				end
			end
			lob_pkg::S_RS_LVL, lob_pkg::S_UN_LVL: lvl_ra = lv_q;
			lob_pkg::S_RS_APP: begin
				// append at the back of the level
				lvl_we = 1'b1;
				lvl_wa = lv_q;
				if (!rd_busy) begin
					lvl_wd = {1'b1, slot_q, slot_q};
				end else begin
					lvl_wd  = {1'b1, rd_head, slot_q};
					next_we = 1'b1; next_wa = rd_tail; next_wd = slot_q;
					prev_we = 1'b1; prev_wa = slot_q;  prev_wd = rd_tail;
				end
				lvs_we  = 1'b1; lvs_wa  = slot_q; lvs_wd  = lv_q;
				used_we = 1'b1; used_wa = slot_q; used_wd = 1'b1;
				remn_we = 1'b1; remn_wa = slot_q; remn_wd = rem_q;
				part_we = 1'b1; part_wa = slot_q; part_wd = rem_q != req_q.quantity;
			end
			lob_pkg::S_UN_DO: begin
				// unlink the cancelled order
				used_we = 1'b1; used_wa = slot_q;
				lvl_wa  = lv_q;
				if (un_empty) begin
					lvl_we = 1'b1;
				end else if (rd_head == slot_q) begin
					lvl_we = 1'b1;
					lvl_wd = {1'b1, unx_q, rd_tail};
				end else if (rd_tail == slot_q) begin
					lvl_we = 1'b1;
					lvl_wd = {1'b1, rd_head, upv_q};
				end else begin
					next_we = 1'b1; next_wa = upv_q; next_wd = unx_q;
					prev_we = 1'b1; prev_wa = unx_q; prev_wd = upv_q;
				end
			end
			lob_pkg::S_SR_RD: lvl_ra = {sr_side_q, sr_t_q};
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lob_pkg::S_CLR;
			clr_q    <= '0;
			n_q      <= '0;
			stop_q   <= 1'b0;
			swept_q  <= 1'b0;
			bid_q    <= '0;
			ask_q    <= '0;
			bid_ok_q <= 1'b0;
			ask_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ev_we) begin
				n_q <= n_q + EW'(1);
			end
			case (state_q)
				lob_pkg::S_CLR: clr_q <= clr_q + CW'(1);
				lob_pkg::S_IDLE: begin
					n_q    <= '0;
					stop_q <= 1'b0;
				end
				lob_pkg::S_CHK: swept_q <= opp_ok;
				lob_pkg::S_SW_HEAD: stop_q <= q_busy && rem_q != 32'd0 && budget_out;
				lob_pkg::S_RS_APP: begin
					// improve own side top
					if (is_buy) begin
						if (!bid_ok_q || lim_q > bid_q) begin
							bid_q    <= lim_q;
							bid_ok_q <= 1'b1;
						end
					end else if (!ask_ok_q || lim_q < ask_q) begin
						ask_q    <= lim_q;
						ask_ok_q <= 1'b1;
					end
				end
				lob_pkg::S_SR_CHK: begin
					if (rd_busy || sr_end) begin
						if (sr_side_q) begin
							ask_q    <= rd_busy ? sr_t_q : '0;
							ask_ok_q <= rd_busy;
						end else begin
							bid_q    <= rd_busy ? sr_t_q : '0;
							bid_ok_q <= rd_busy;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		case (state_q)
			lob_pkg::S_IDLE: begin
				if (req_valid) begin
					req_q  <= req;
					slot_q <= SW'(req.order_id);
					lim_q  <= lim_in;
					rem_q  <= req.quantity;
					acc_q  <= '0;
				end
			end
			lob_pkg::S_CHK: begin
				t_q   <= is_buy ? ask_q : bid_q;
				lv_q  <= is_cancel ? lvs_rd : {req_q.side, lim_q};
				unx_q <= next_rd;
				upv_q <= prev_rd;
			end
			lob_pkg::S_SW_LAT: lvl_q <= lvl_rd;
			lob_pkg::S_SW_TRADE: begin
				rem_q <= trade.aggr_left;
				acc_q <= trade.acc_sum;
				if (trade.rest_done) begin
					lvl_q <= (q_tail == q_head) ? '0 : {1'b1, next_rd, q_tail};
				end
			end
			lob_pkg::S_SW_LVEND: begin
				acc_q <= '0;
				if (state_d == lob_pkg::S_SW_LVL) begin
					t_q <= is_buy ? t_q + LW'(1) : t_q - LW'(1);
				end
			end
			lob_pkg::S_SW_END: begin
				sr_side_q <= ~req_q.side;
				sr_t_q    <= t_q;
			end
			lob_pkg::S_UN_DO: begin
				sr_side_q <= lv_q[LW];
				sr_t_q    <= lv_q[LW-1:0];
			end
			lob_pkg::S_SR_CHK: begin
				if (!rd_busy && !sr_end) begin
					sr_t_q <= sr_side_q ? sr_t_q + LW'(1) : sr_t_q - LW'(1);
				end
			end
			default: ;
		endcase
	end

	// replay hand-off
	always_comb begin
		ev_start   = state_q == lob_pkg::S_OUT_GO && n_q != '0;
		top.bid    = 10'(bid_q);
		top.bid_ok = bid_ok_q;
		top.ask    = 10'(ask_q);
		top.ask_ok = ask_ok_q;
		req_stall  = state_q != lob_pkg::S_IDLE;
	end

	lob_evbuf #(
		.MAX_EVENTS (MAX_EVENTS)
	) u_evbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_we     (ev_we),
		.ev_addr   (n_q),
		.ev_rec    (ev_rec),
		.start     (ev_start),
		.count     (n_q),
		.top       (top),
		.busy      (ev_busy),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

endmodule
